// ===== src/utu_pkg.sv =====
// ----------------------------------------------------------------------------
// utu_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package utu_pkg;

  localparam int unsigned UnitW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned MaxBytes = 4;
  localparam int unsigned IdxW     = 2;   // index of a byte within one job

  // surrogate ranges
  localparam logic [UnitW-1:0] LeadLo    = 16'hD800;
  localparam logic [UnitW-1:0] LeadHi    = 16'hDBFF;
  localparam logic [UnitW-1:0] TrailMask = 16'hFC00;
  localparam logic [UnitW-1:0] TrailBase = 16'hDC00;

  // encoding limits
  localparam logic [UnitW-1:0] OneByteMax = 16'h007F;
  localparam logic [UnitW-1:0] TwoByteMax = 16'h07FF;

  // code point of a surrogate pair is 21 bits wide
  localparam int unsigned        CpW        = 21;
  localparam logic [CpW-1:0]     SuppOffset = 21'h10000;

  // leading byte markers
  localparam logic [ByteW-1:0] Lead4Mark = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Mark = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Mark = 8'hC0;
  localparam logic [ByteW-1:0] ContMark  = 8'h80;

  // one queued job: the bytes caused by one code unit, first byte at index 0
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] data;
    logic [IdxW-1:0]                last_idx;
  } job_t;

endpackage

// ===== src/utu_front.sv =====
// ----------------------------------------------------------------------------
// utu_front
// Accepts code units, tracks a pending lead surrogate and builds byte jobs.
// ----------------------------------------------------------------------------
module utu_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [utu_pkg::UnitW-1:0]   code_unit_i,
  input  logic                        string_end_i,
  output logic                        push_o,
  output utu_pkg::job_t               job_o,
  input  logic                        full_i
);

  logic        lead_held_q, lead_held_d;
  logic [9:0]  lead_bits_q;
  logic        accept;
  logic        is_trail, is_lead, is_pair, do_hold, do_bmp;
  logic [utu_pkg::CpW-1:0] cp;
  logic [utu_pkg::UnitW-1:0] u;

  assign u          = code_unit_i;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // classify the unit
  assign is_trail = (u & utu_pkg::TrailMask) == utu_pkg::TrailBase;
  assign is_lead  = (u >= utu_pkg::LeadLo) && (u <= utu_pkg::LeadHi);
  assign is_pair  = lead_held_q && is_trail;
  assign do_hold  = !is_pair && is_lead && !string_end_i;
  assign do_bmp   = !is_pair && !is_trail && !do_hold;

  assign cp = utu_pkg::SuppOffset + {1'b0, lead_bits_q, u[9:0]};

  // build the byte job
  always_comb begin
    job_o = '0;
    if (is_pair) begin
      job_o.data[0]  = {5'b0, cp[20:18]} | utu_pkg::Lead4Mark;
      job_o.data[1]  = {2'b0, cp[17:12]} | utu_pkg::ContMark;
      job_o.data[2]  = {2'b0, cp[11:6]}  | utu_pkg::ContMark;
      job_o.data[3]  = {2'b0, cp[5:0]}   | utu_pkg::ContMark;
      job_o.last_idx = 2'd3;
    end else if (u <= utu_pkg::OneByteMax) begin
      job_o.data[0]  = u[7:0];
      job_o.last_idx = 2'd0;
    end else if (u <= utu_pkg::TwoByteMax) begin
      job_o.data[0]  = {3'b0, u[10:6]} | utu_pkg::Lead2Mark;
      job_o.data[1]  = {2'b0, u[5:0]}  | utu_pkg::ContMark;
      job_o.last_idx = 2'd1;
    end else begin
      job_o.data[0]  = {4'b0, u[15:12]} | utu_pkg::Lead3Mark;
      job_o.data[1]  = {2'b0, u[11:6]}  | utu_pkg::ContMark;
      job_o.data[2]  = {2'b0, u[5:0]}   | utu_pkg::ContMark;
      job_o.last_idx = 2'd2;
    end
  end

  assign push_o = accept && (is_pair || do_bmp);

  // pending lead surrogate
  assign lead_held_d = accept ? do_hold : lead_held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_held_q <= 1'b0;
    end else begin
      lead_held_q <= lead_held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && do_hold) begin
      lead_bits_q <= u[9:0];
    end
  end

endmodule

// ===== src/utu_queue.sv =====
// ----------------------------------------------------------------------------
// utu_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module utu_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  utu_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output utu_pkg::job_t job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  utu_pkg::job_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== src/utu_back.sv =====
// ----------------------------------------------------------------------------
// utu_back
// Holds one job and sends its bytes one byte at a time.
// ----------------------------------------------------------------------------
module utu_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  utu_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [utu_pkg::ByteW-1:0]   out_byte_o,
  output logic                        run_last_o
);

  utu_pkg::job_t               job_q, job_d;
  logic                        busy_q, busy_d;
  logic [utu_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                        sent, at_last;

  assign out_valid_o = busy_q;
  assign out_byte_o  = job_q.data[idx_q];
  assign at_last     = idx_q == job_q.last_idx;
  assign run_last_o  = at_last;
  assign sent        = busy_q && out_ready_i;

  // load a new job when idle or when the last byte goes out
  assign pop_o = !empty_i && (!busy_q || (sent && at_last));

  always_comb begin
    job_d  = job_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      job_d  = job_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (sent) begin
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

// ===== src/utf16_to_utf8_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out.
// ----------------------------------------------------------------------------
// The block takes one UTF-16 code unit per cycle while in_ready_o is high and
// sends one UTF-8 byte per cycle while out_ready_i is high. A unit that gives
// one byte passes at a full unit per cycle; a unit that gives n bytes sends
// them in turn on the single byte lane of the output stage, which sets the
// sustained input rate. A lead surrogate that is followed by another unit
// gives no bytes of its own; a surrogate pair gives four bytes on the trail,
// and run_last_o marks the final byte caused by each unit. A job queue of
// QueueDepth entries lets the input keep flowing while the output is stalled.
module utf16_to_utf8_transcoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [utu_pkg::UnitW-1:0]   code_unit_i,
  input  logic                        string_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [utu_pkg::ByteW-1:0]   out_byte_o,
  output logic                        run_last_o
);

  logic          push, full, pop, empty;
  utu_pkg::job_t front_job, head_job;

  // classify units and build jobs
  utu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .string_end_i (string_end_i),
    .push_o       (push),
    .job_o        (front_job),
    .full_i       (full)
  );

  // job queue
  utu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  // byte sender
  utu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule
